// File: rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg: shared definitions for the handle slot table
// Table geometry, port widths, request codes and the structs that travel
// between the controller and the occupancy cells.
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_WIDTH = 32;

	// occupancy bits held by one cell of the scan chain
	localparam int SEG_W   = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
	localparam int N_CELLS = (TABLE_DEPTH + SEG_W - 1) / SEG_W;
	localparam int OFF_W   = $clog2(SEG_W);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int GI_W  = IDX_W + 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// port widths
	localparam int RTYPE_W = 3;
	localparam int KEY_W   = 8;
	localparam int ENTRY_W = 32;
	localparam int RV_W    = 32;
	localparam int RI_W    = 9;
	localparam int OC_W    = 9;

	typedef enum logic [RTYPE_W-1:0] {
		REQ_LOOKUP     = 3'd0,
		REQ_WRITE      = 3'd1,
		REQ_ALLOC      = 3'd2,
		REQ_REMOVE     = 3'd3,
		REQ_NEXT_OCC   = 3'd4,
		REQ_NEXT_EMPTY = 3'd5
	} req_t;

	// scan token passed from cell to cell
	typedef struct packed {
		logic            active;
		logic            found;
		logic            want;
		logic [GI_W-1:0] start;
		logic [GI_W-1:0] idx;
	} scan_tok_t;

	// occupancy update broadcast to all cells
	typedef struct packed {
		logic            en;
		logic [GI_W-1:0] addr;
		logic            occ;
	} map_wr_t;

endpackage

// File: rtl/hst_cell.sv
// ----------------------------------------------------------------------------
// hst_cell: one segment of the occupancy map
// Holds SEG_W occupancy bits, applies broadcast updates and, when the scan
// token passes, marks the first matching slot at or after the start index.
// ----------------------------------------------------------------------------
module hst_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hst_pkg::GI_W-1:0]  base,
	input  hst_pkg::map_wr_t          map_wr,
	input  hst_pkg::scan_tok_t        tok_in,
	output hst_pkg::scan_tok_t        tok_out,
	output logic [hst_pkg::SEG_W-1:0] occ
);
	import hst_pkg::*;

	logic [SEG_W-1:0] occ_q;
	scan_tok_t        tok_q;
	scan_tok_t        tok_next;
	logic [GI_W-1:0]  rel;
	logic             wr_hit;
	logic [OFF_W-1:0] wr_off;
	logic [SEG_W-1:0] hit;
	logic             any_hit;
	logic [OFF_W-1:0] hit_off;

	assign rel    = map_wr.addr - base;
	assign wr_hit = map_wr.en && (map_wr.addr >= base) && (rel < GI_W'(SEG_W));
	assign wr_off = rel[OFF_W-1:0];

	always_comb begin
		for (int j = 0; j < SEG_W; j++) begin
			hit[j] = (occ_q[j] == tok_in.want)
				&& ((base + GI_W'(j)) >= tok_in.start)
				&& ((base + GI_W'(j)) < GI_W'(TABLE_DEPTH));
		end
		any_hit = |hit;
		hit_off = '0;
		for (int j = SEG_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_off = OFF_W'(j);
			end
		end
		tok_next = tok_in;
		// first cell with a match claims the token; later cells pass it on
		if (tok_in.active && !tok_in.found && any_hit) begin
			tok_next.found = 1'b1;
			tok_next.idx   = base + GI_W'(hit_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			tok_q <= '0;
		end else begin
			if (wr_hit) begin
				occ_q[wr_off] <= map_wr.occ;
			end
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;
	assign occ     = occ_q;

endmodule

// File: rtl/handle_slot_table.sv
// ----------------------------------------------------------------------------
// handle_slot_table: fixed table of handle slots with first-free allocation
// Value memory plus a chain of occupancy cells that carries scan requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with req_type, slot_key, entry_value;
//   one result per request leaves on out_valid/out_ready. The block works on
//   one item at a time: in_ready is high only when no request is in flight.
//   Lookup, write and remove do a read-modify-write of the value memory in
//   ST_RMW, then pass through ST_DONE to the output register; the next item
//   is taken once the block is back in ST_IDLE.
//   Allocate, next-occupied and next-empty send a token down the chain of
//   N_CELLS occupancy cells (8 for 256 slots), one cell per cycle, and the
//   result is taken from the last cell; a next-occupied hit adds a memory
//   read of the found slot in ST_FETCH.
//   Reset clears the occupancy map and count at once, so every slot reads as
//   empty right away; the value memory itself is not swept, since a slot
//   whose occupancy bit is clear always reads as zero.
//   A result waits in the output register while the receiver stalls; a new
//   item is still accepted meanwhile, and its result holds until the
//   register is free.
// ----------------------------------------------------------------------------
module handle_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hst_pkg::RTYPE_W-1:0] req_type,
	input  logic [hst_pkg::KEY_W-1:0]   slot_key,
	input  logic [hst_pkg::ENTRY_W-1:0] entry_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hst_pkg::RV_W-1:0]    result_value,
	output logic [hst_pkg::RI_W-1:0]    result_index,
	output logic [hst_pkg::OC_W-1:0]    occupied_count,
	output logic                        status
);
	import hst_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RMW   = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	req_t                   req_q;
	logic                   inside_q;
	logic [IDX_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [VALUE_WIDTH-1:0] slot_mem [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;

	map_wr_t                  map_wr;
	scan_tok_t                tok_start;
	scan_tok_t                tok_link [N_CELLS];
	scan_tok_t                tok_end;
	logic [N_CELLS*SEG_W-1:0] map_all;

	logic [CNT_W-1:0]       count_q, count_d;
	logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
	logic [GI_W-1:0]        res_index_q, res_index_d;
	logic                   res_status_q, res_status_d;

	logic              out_valid_q;
	logic [RV_W-1:0]   result_value_q;
	logic [RI_W-1:0]   result_index_q;
	logic [OC_W-1:0]   count_out_q;
	logic              status_q;

	logic                   accept;
	logic                   load_out;
	req_t                   in_req;
	logic                   in_inside;
	logic [GI_W-1:0]        in_key_g;
	logic                   old_occ;
	logic [VALUE_WIDTH-1:0] old_val;
	logic                   new_occ;
	logic [GI_W-1:0]        found_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_req    = req_t'(req_type);
	assign in_inside = (32'(slot_key) < 32'(TABLE_DEPTH));
	assign in_key_g  = GI_W'(slot_key);
	assign old_occ   = map_all[key_q];
	assign old_val   = old_occ ? rd_q : '0;
	assign new_occ   = |val_q;
	assign found_idx = tok_end.found ? tok_end.idx : GI_W'(TABLE_DEPTH);

	// occupancy chain
	for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
		scan_tok_t tok_in_c;
		if (c == 0) begin : g_head
			assign tok_in_c = tok_start;
		end else begin : g_body
			assign tok_in_c = tok_link[c-1];
		end
		hst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.base    (GI_W'(c * SEG_W)),
			.map_wr  (map_wr),
			.tok_in  (tok_in_c),
			.tok_out (tok_link[c]),
			.occ     (map_all[c*SEG_W +: SEG_W])
		);
	end
	assign tok_end = tok_link[N_CELLS-1];

	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		rd_addr      = in_key_g[IDX_W-1:0];
		wr_en        = 1'b0;
		wr_addr      = key_q;
		map_wr.en    = 1'b0;
		map_wr.addr  = GI_W'(key_q);
		map_wr.occ   = 1'b0;
		count_d      = count_q;
		res_value_d  = res_value_q;
		res_index_d  = res_index_q;
		res_status_d = res_status_q;
		tok_start    = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_value_d  = '0;
					res_index_d  = '0;
					res_status_d = 1'b0;
					case (in_req)
						REQ_LOOKUP, REQ_WRITE, REQ_REMOVE: begin
							rd_en   = 1'b1;
							state_d = ST_RMW;
						end
						REQ_ALLOC, REQ_NEXT_OCC, REQ_NEXT_EMPTY: begin
							tok_start.active = 1'b1;
							tok_start.want   = (in_req == REQ_NEXT_OCC);
							if (in_req == REQ_ALLOC) begin
								tok_start.start = '0;
							end else if (in_inside) begin
								tok_start.start = in_key_g;
							end else begin
								tok_start.start = GI_W'(TABLE_DEPTH);
							end
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_RMW: begin
				case (req_q)
					REQ_LOOKUP: begin
						if (inside_q) begin
							res_value_d = old_val;
						end
					end
					REQ_WRITE: begin
						if (inside_q) begin
							res_value_d = old_val;
							wr_en       = 1'b1;
							map_wr.en   = 1'b1;
							map_wr.occ  = new_occ;
							count_d     = count_q + CNT_W'(new_occ) - CNT_W'(old_occ);
						end
					end
					REQ_REMOVE: begin
						if (inside_q) begin
							map_wr.en = 1'b1;
							count_d   = count_q - CNT_W'(old_occ);
						end
					end
					default: begin
					end
				endcase
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (tok_end.active) begin
					res_index_d = found_idx;
					state_d     = ST_DONE;
					case (req_q)
						REQ_ALLOC: begin
							if (tok_end.found) begin
								// slot was empty, so the count only grows
								wr_en       = 1'b1;
								wr_addr     = tok_end.idx[IDX_W-1:0];
								map_wr.en   = 1'b1;
								map_wr.addr = tok_end.idx;
								map_wr.occ  = new_occ;
								count_d     = count_q + CNT_W'(new_occ);
							end else begin
								res_status_d = 1'b1;
							end
						end
						REQ_NEXT_OCC: begin
							if (tok_end.found) begin
								rd_en   = 1'b1;
								rd_addr = tok_end.idx[IDX_W-1:0];
								state_d = ST_FETCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FETCH: begin
				res_value_d = rd_q;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= in_req;
			key_q    <= in_key_g[IDX_W-1:0];
			inside_q <= in_inside;
			val_q    <= VALUE_WIDTH'(entry_value);
		end
		res_value_q  <= res_value_d;
		res_index_q  <= res_index_d;
		res_status_q <= res_status_d;
		if (load_out) begin
			result_value_q <= RV_W'(res_value_q);
			result_index_q <= RI_W'(res_index_q);
			count_out_q    <= OC_W'(count_q);
			status_q       <= res_status_q;
		end
	end

	// value memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= val_q;
		end
		if (rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = result_value_q;
	assign result_index   = result_index_q;
	assign occupied_count = count_out_q;
	assign status         = status_q;

	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(map_all) == int'(count_q))
		else $error("occupied count out of step with occupancy map");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("occupied count above table depth");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.active |-> state_q == ST_SCAN)
		else $error("scan token left the chain outside a scan");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> result_index == RI_W'(TABLE_DEPTH))
		else $error("full-table status without none-found index");

endmodule

// File: tb/handle_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_slot_table_tb: self-checking bench for the handle slot table
// Drives lookup, write, allocate, remove and both scans through the request
// channel with bursty timing, predicts every result from a shadow copy of the
// table, and checks each returned item field by field under a stalling sink.
// ----------------------------------------------------------------------------
module handle_slot_table_tb;
	import hst_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MIX_ITEMS    = 200;

	// request codes the block does not define
	localparam logic [RTYPE_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [RTYPE_W-1:0] REQ_UNUSED_7 = 3'd7;

	typedef struct {
		logic [RTYPE_W-1:0] kind;
		logic [KEY_W-1:0]   key;
		logic [ENTRY_W-1:0] value;
	} table_req_t;

	typedef struct {
		logic [RV_W-1:0] value;
		logic [RI_W-1:0] index;
		logic [OC_W-1:0] count;
		logic            full;
	} table_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [RTYPE_W-1:0]   req_type;
	logic [KEY_W-1:0]     slot_key;
	logic [ENTRY_W-1:0]   entry_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [RV_W-1:0]      result_value;
	logic [RI_W-1:0]      result_index;
	logic [OC_W-1:0]      occupied_count;
	logic                 status;

	table_req_t    pending_requests[$];
	table_result_t expected_results[$];

	// shadow table
	logic [VALUE_WIDTH-1:0] shadow_slots[TABLE_DEPTH];
	int                     shadow_count;

	logic item_taken;
	int   burst_left;
	int   gap_left;
	logic [15:0] ready_pattern;
	logic [5:0]  ready_phase;

	int cycle_count;
	int error_count;
	int n_requests;
	int n_results;
	int n_full_refusals;
	int n_scan_misses;

	handle_slot_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.slot_key       (slot_key),
		.entry_value    (entry_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_value   (result_value),
		.result_index   (result_index),
		.occupied_count (occupied_count),
		.status         (status)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void store_slot(input int k, input logic [VALUE_WIDTH-1:0] v);
		if (v != '0 && shadow_slots[k] == '0)
			shadow_count++;
		else if (v == '0 && shadow_slots[k] != '0)
			shadow_count--;
		shadow_slots[k] = v;
	endfunction

	// lowest slot at or after start whose occupancy matches want
	function automatic int scan_slots(input int start, input bit want);
		int i;
		int hit;
		hit = TABLE_DEPTH;
		for (i = TABLE_DEPTH - 1; i >= start; i--)
			if ((shadow_slots[i] != '0) == want)
				hit = i;
		return hit;
	endfunction

	function automatic table_result_t apply_table_request(input table_req_t rq);
		table_result_t r;
		int            k;
		int            hit;
		k       = int'(rq.key);
		r.value = '0;
		r.index = '0;
		r.full  = 1'b0;
		case (rq.kind)
			REQ_LOOKUP: begin
				if (k < TABLE_DEPTH)
					r.value = shadow_slots[k];
			end
			REQ_WRITE: begin
				if (k < TABLE_DEPTH) begin
					r.value = shadow_slots[k];
					store_slot(k, rq.value[VALUE_WIDTH-1:0]);
				end
			end
			REQ_ALLOC: begin
				hit     = scan_slots(0, 1'b0);
				r.index = RI_W'(hit);
				if (hit < TABLE_DEPTH)
					store_slot(hit, rq.value[VALUE_WIDTH-1:0]);
				else
					r.full = 1'b1;
			end
			REQ_REMOVE: begin
				if (k < TABLE_DEPTH)
					store_slot(k, '0);
			end
			REQ_NEXT_OCC: begin
				hit     = (k < TABLE_DEPTH) ? scan_slots(k, 1'b1) : TABLE_DEPTH;
				r.index = RI_W'(hit);
				if (hit < TABLE_DEPTH)
					r.value = shadow_slots[hit];
			end
			REQ_NEXT_EMPTY: begin
				hit     = (k < TABLE_DEPTH) ? scan_slots(k, 1'b0) : TABLE_DEPTH;
				r.index = RI_W'(hit);
			end
			default: begin
			end
		endcase
		r.count = OC_W'(shadow_count);
		return r;
	endfunction

	function automatic table_req_t random_request(input bit remove_heavy);
		table_req_t r;
		int         pick;
		int         sel;
		pick = $urandom_range(0, 99);
		if (remove_heavy) begin
			if (pick < 30)      r.kind = REQ_REMOVE;
			else if (pick < 45) r.kind = REQ_LOOKUP;
			else if (pick < 60) r.kind = REQ_WRITE;
			else if (pick < 70) r.kind = REQ_ALLOC;
			else if (pick < 82) r.kind = REQ_NEXT_OCC;
			else if (pick < 94) r.kind = REQ_NEXT_EMPTY;
			else                r.kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
		end else begin
			if (pick < 15)      r.kind = REQ_LOOKUP;
			else if (pick < 35) r.kind = REQ_WRITE;
			else if (pick < 60) r.kind = REQ_ALLOC;
			else if (pick < 70) r.kind = REQ_REMOVE;
			else if (pick < 82) r.kind = REQ_NEXT_OCC;
			else if (pick < 94) r.kind = REQ_NEXT_EMPTY;
			else                r.kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
		end
		// keep most keys in the low region where allocate puts its handles
		sel = $urandom_range(0, 9);
		if (sel < 5)       r.key = KEY_W'($urandom_range(0, 63));
		else if (sel == 5) r.key = '0;
		else if (sel == 6) r.key = '1;
		else               r.key = KEY_W'($urandom);
		sel = $urandom_range(0, 9);
		case (sel)
			0:       r.value = '0;
			1:       r.value = '1;
			2:       r.value = 32'h0000_0001;
			3:       r.value = 32'h8000_0000;
			default: r.value = $urandom;
		endcase
		return r;
	endfunction

	task automatic push_request(input logic [RTYPE_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [ENTRY_W-1:0] value);
		table_req_t r;
		r.kind  = kind;
		r.key   = key;
		r.value = value;
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// request driver: bursts with random gaps, payload changes on the falling edge
	initial begin
		in_valid    = 1'b0;
		req_type    = '0;
		slot_key    = '0;
		entry_value = '0;
		burst_left  = 1;
		gap_left    = 0;
	end

	always @(negedge clk) begin
		table_req_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !item_taken) begin
			// hold until accepted
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_requests.size() != 0) begin
			rq = pending_requests.pop_front();
			req_type    <= rq.kind;
			slot_key    <= rq.key;
			entry_value <= rq.value;
			in_valid    <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result sink: stall pattern reloaded whenever the 6-bit phase counter wraps
	initial begin
		out_ready     = 1'b0;
		ready_pattern = '1;
		ready_phase   = '0;
	end

	always @(negedge clk) begin
		logic [15:0] next_pattern;
		next_pattern = ready_pattern;
		if (ready_phase == '0) begin
			case ($urandom_range(0, 3))
				0:       next_pattern = '1;
				1:       next_pattern = 16'($urandom) | 16'h0001;
				2:       next_pattern = 16'($urandom & $urandom) | 16'h0001;
				default: next_pattern = 16'($urandom | $urandom);
			endcase
			ready_pattern <= next_pattern;
		end
		out_ready   <= next_pattern[ready_phase[3:0]];
		ready_phase <= ready_phase + 6'd1;
	end

	// monitor: check returned items first, then record the newly accepted one
	initial begin
		item_taken   = 1'b0;
		shadow_count = 0;
		error_count  = 0;
		n_requests   = 0;
		n_results    = 0;
		n_full_refusals = 0;
		n_scan_misses   = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			shadow_slots[i] = '0;
	end

	always @(posedge clk) begin
		table_result_t exp_r;
		table_req_t    rq;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request waiting: value %h index %0d count %0d status %b",
						$time, result_value, result_index, occupied_count, status);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (result_value !== exp_r.value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, exp_r.value, result_value);
						error_count++;
					end
					if (result_index !== exp_r.index) begin
						$display("%0t: result_index expected %0d actual %0d",
							$time, exp_r.index, result_index);
						error_count++;
					end
					if (occupied_count !== exp_r.count) begin
						$display("%0t: occupied_count expected %0d actual %0d",
							$time, exp_r.count, occupied_count);
						error_count++;
					end
					if (status !== exp_r.full) begin
						$display("%0t: status expected %b actual %b",
							$time, exp_r.full, status);
						error_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				rq.kind  = req_type;
				rq.key   = slot_key;
				rq.value = entry_value;
				exp_r = apply_table_request(rq);
				if (exp_r.full)
					n_full_refusals++;
				if ((rq.kind == REQ_NEXT_OCC || rq.kind == REQ_NEXT_EMPTY)
						&& exp_r.index == RI_W'(TABLE_DEPTH))
					n_scan_misses++;
				expected_results.push_back(exp_r);
				n_requests++;
			end
		end
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int fill_count;
		int v;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, zero stores, scans off both ends
		push_request(REQ_LOOKUP,     8'd0,   32'hFFFF_FFFF);
		push_request(REQ_NEXT_OCC,   8'd0,   32'h0);
		push_request(REQ_NEXT_EMPTY, 8'd255, 32'h0);
		push_request(REQ_ALLOC,      8'd255, 32'hFFFF_FFFF);
		push_request(REQ_ALLOC,      8'd0,   32'h0000_0001);
		push_request(REQ_ALLOC,      8'd17,  32'h0);
		push_request(REQ_WRITE,      8'd255, 32'hA5A5_5A5A);
		push_request(REQ_WRITE,      8'd255, 32'h8000_0000);
		push_request(REQ_LOOKUP,     8'd255, 32'h0);
		push_request(REQ_NEXT_OCC,   8'd2,   32'h0);
		push_request(REQ_NEXT_OCC,   8'd255, 32'h0);
		push_request(REQ_NEXT_EMPTY, 8'd0,   32'h0);
		push_request(REQ_WRITE,      8'd1,   32'h0);
		push_request(REQ_NEXT_EMPTY, 8'd1,   32'h0);
		push_request(REQ_REMOVE,     8'd200, 32'hFFFF_FFFF);
		push_request(REQ_REMOVE,     8'd255, 32'h0);
		push_request(REQ_NEXT_OCC,   8'd1,   32'h0);
		push_request(REQ_LOOKUP,     8'd0,   32'h0);
		push_request(REQ_UNUSED_6,   8'd255, 32'hFFFF_FFFF);
		push_request(REQ_UNUSED_7,   8'd0,   32'h0);
		push_request(REQ_ALLOC,      8'd128, 32'h5555_AAAA);
		push_request(REQ_WRITE,      8'd0,   32'h0);

		for (int i = 0; i < MIX_ITEMS; i++)
			pending_requests.push_back(random_request(1'b0));

		// pause until everything has come back, then fill the table to the brim
		wait_drained();
		fill_count = TABLE_DEPTH - shadow_count;
		for (int i = 0; i < fill_count; i++) begin
			do v = $urandom; while (v == 0);
			push_request(REQ_ALLOC, KEY_W'($urandom), ENTRY_W'(v));
		end
		push_request(REQ_ALLOC,      8'd0,   32'hFFFF_FFFF);
		push_request(REQ_NEXT_EMPTY, 8'd0,   32'h0);
		push_request(REQ_NEXT_EMPTY, 8'd255, 32'h0);
		push_request(REQ_NEXT_OCC,   8'd255, 32'h0);
		push_request(REQ_ALLOC,      8'd42,  32'h1234_5678);
		push_request(REQ_REMOVE,     8'd128, 32'h0);
		push_request(REQ_ALLOC,      8'd0,   32'hDEAD_BEEF);
		push_request(REQ_ALLOC,      8'd0,   32'h0000_0001);

		// drain it again with removes mixed in
		for (int i = 0; i < 150; i++)
			pending_requests.push_back(random_request(1'b1));
		wait_drained();
		for (int i = 0; i < 120; i++)
			pending_requests.push_back(random_request(1'b0));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			error_count++;
		end

		$display("Ran %0d table requests and checked %0d results, %0d mismatches.",
			n_requests, n_results, error_count);
		$display("Allocate refused on a full table %0d times; scans found nothing %0d times.",
			n_full_refusals, n_scan_misses);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
